// File: hdl/sha256mh_pkg.sv
package sha256mh_pkg;

  // One input word: an optional message byte and an end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  // One output word: a digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_word_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_PAD_MARK,
    SEL_ZERO,
    SEL_LENGTH
  } byte_sel_e;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Controller to datapath commands.
  typedef struct packed {
    logic      byte_shift;
    byte_sel_e byte_sel;
    logic [2:0] len_idx;
    logic      count_bits;
    logic      clear_bits;
    logic      load_vars;
    logic      round_en;
    logic [5:0] round_idx;
    logic      add_hash;
    logic      emit_shift;
    logic [2:0] emit_idx;
  } dp_cmd_t;

endpackage

// File: hdl/sha256mh_dp.sv
module sha256mh_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha256mh_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]           data_byte_i,
  output logic [31:0]          digest_word_o
);

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Block buffer and schedule window share one 512-bit shift line; word 0 at the top.
  logic [511:0] win_q;
  logic [511:0] win_d;
  logic [31:0]  vars_q [8];
  logic [31:0]  hash_q [8];
  logic [63:0]  bits_q;

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_next;
  logic [31:0] a, b, c, e, f, g, h;
  logic [31:0] t1, t2;

  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];

  // Word sixteen rounds ahead of the one used now.
  assign w_next = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  always_comb begin
    unique case (cmd_i.byte_sel)
      sha256mh_pkg::SEL_INPUT:    byte_in = data_byte_i;
      sha256mh_pkg::SEL_PAD_MARK: byte_in = sha256mh_pkg::PAD_MARK;
      sha256mh_pkg::SEL_ZERO:     byte_in = 8'h00;
      sha256mh_pkg::SEL_LENGTH:   byte_in = bits_q[{~cmd_i.len_idx, 3'b000} +: 8];
      default:                    byte_in = 8'h00;
    endcase
  end

  always_comb begin
    win_d = win_q;
    if (cmd_i.byte_shift) begin
      win_d = {win_q[503:0], byte_in};
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_next};
    end
  end

  assign a = vars_q[0];
  assign b = vars_q[1];
  assign c = vars_q[2];
  assign e = vars_q[4];
  assign f = vars_q[5];
  assign g = vars_q[6];
  assign h = vars_q[7];

  assign t1 = h + big_sigma1(e) + ((e & f) ^ (~e & g)) + ROUND_K[cmd_i.round_idx] + w0;
  assign t2 = big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.load_vars) begin
      for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
    end else if (cmd_i.round_en) begin
      vars_q[7] <= g;
      vars_q[6] <= f;
      vars_q[5] <= e;
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= c;
      vars_q[2] <= b;
      vars_q[1] <= a;
      vars_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= HASH_IV[i];
      bits_q <= '0;
    end else begin
      priority if (cmd_i.add_hash) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[i];
      end else if (cmd_i.emit_shift) begin
        // Shift the digest out and refill with the initial values behind it.
        for (int i = 0; i < 7; i++) hash_q[i] <= hash_q[i+1];
        hash_q[7] <= HASH_IV[cmd_i.emit_idx];
      end
      if (cmd_i.clear_bits) begin
        bits_q <= '0;
      end else if (cmd_i.count_bits) begin
        bits_q <= bits_q + 64'd8;
      end
    end
  end

  assign digest_word_o = hash_q[0];

endmodule

// File: hdl/sha256mh_ctrl.sv
module sha256mh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  byte_present_i,
  input  logic                  end_of_message_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            word_number_o,
  output sha256mh_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] round_q, round_d;
  logic [2:0] word_q, word_d;
  logic       end_q, end_d;
  logic       pad_first_q, pad_first_d;
  logic       pad_wrap_q, pad_wrap_d;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    round_d     = round_q;
    word_d      = word_q;
    end_d       = end_q;
    pad_first_d = pad_first_q;
    pad_wrap_d  = pad_wrap_q;

    cmd_o            = '0;
    cmd_o.byte_sel   = sha256mh_pkg::SEL_INPUT;
    cmd_o.len_idx    = fill_q[2:0];
    cmd_o.round_idx  = round_q;
    cmd_o.emit_idx   = word_q;

    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.byte_shift = 1'b1;
            cmd_o.count_bits = 1'b1;
            fill_d = fill_q + 6'd1;
          end
          if (byte_present_i && (&fill_q)) begin
            state_d     = ST_LOAD;
            end_d       = end_of_message_i;
            pad_first_d = 1'b1;
          end else if (end_of_message_i) begin
            state_d     = ST_PAD;
            end_d       = 1'b1;
            pad_first_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd_o.byte_shift = 1'b1;
        priority if (pad_first_q) begin
          cmd_o.byte_sel = sha256mh_pkg::SEL_PAD_MARK;
        end else if ((fill_q[5:3] == 3'b111) && !pad_wrap_q) begin
          cmd_o.byte_sel = sha256mh_pkg::SEL_LENGTH;
        end else begin
          cmd_o.byte_sel = sha256mh_pkg::SEL_ZERO;
        end
        // Marker too late for the length: finish this block with zeros.
        if (pad_first_q && (fill_q[5:3] == 3'b111)) pad_wrap_d = 1'b1;
        pad_first_d = 1'b0;
        fill_d      = fill_q + 6'd1;
        if (&fill_q) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_vars = 1'b1;
        round_d = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (&round_q) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_hash = 1'b1;
        priority if (!end_q) begin
          state_d = ST_IDLE;
        end else if (pad_first_q) begin
          state_d = ST_PAD;
        end else if (pad_wrap_q) begin
          pad_wrap_d = 1'b0;
          state_d    = ST_PAD;
        end else begin
          word_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          cmd_o.emit_shift = 1'b1;
          word_d = word_q + 3'd1;
          if (&word_q) begin
            cmd_o.clear_bits = 1'b1;
            end_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      round_q     <= '0;
      word_q      <= '0;
      end_q       <= 1'b0;
      pad_first_q <= 1'b0;
      pad_wrap_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      round_q     <= round_d;
      word_q      <= word_d;
      end_q       <= end_d;
      pad_first_q <= pad_first_d;
      pad_wrap_q  <= pad_wrap_d;
    end
  end

  assign word_number_o = word_q;

endmodule

// File: hdl/sha256_message_hasher_unit.sv
// SHA-256 hasher over a byte stream.
// Input channel: one word per handshake carries an optional message byte
// (byte_present) and an end-of-message flag; both may come in one word.
// Output channel: after each message, eight digest words in order, word 0
// first, each big-endian, word_number 0..7, last_word set on word 7.
// Flow: a word with no block completion is taken without a stall. The 64th
// byte of a block is followed by the compression (load, 64 rounds, hash add),
// done by the single round unit that runs one round per cycle.
// End of message: padding bytes go through the same byte path, one a cycle,
// until the block is full (64 minus the bytes it already holds), then the
// compression; when the length field does not fit, a second padding block and
// compression follow. The digest words follow, one per cycle while not stalled.
// in_stall_o is high whenever the block is busy compressing, padding or
// emitting; the next message may start right after the last digest word.
// When the receiver stalls, the current digest word holds and the block waits.
// Reset: hash returns to the initial values, byte and bit counts clear,
// no output is pending. Each digest also leaves the block in that state.
module sha256_message_hasher_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sha256mh_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sha256mh_pkg::out_word_t out_data_o
);

  sha256mh_pkg::dp_cmd_t cmd;
  logic [31:0]           digest_word;
  logic [2:0]            word_number;

  // Sequence loading, padding, rounds and digest output.
  sha256mh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .byte_present_i   (in_data_i.byte_present),
    .end_of_message_i (in_data_i.end_of_message),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .word_number_o    (word_number),
    .cmd_o            (cmd)
  );

  // Hold the block buffer, schedule, working variables, hash words and bit count.
  sha256mh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_data_i.data_byte),
    .digest_word_o (digest_word)
  );

  // Digest word comes straight from the head of the hash register line.
  assign out_data_o.digest_word = digest_word;
  assign out_data_o.word_number = word_number;
  assign out_data_o.last_word   = &word_number;

endmodule

// File: tb/tb_sha256_message_hasher_unit.sv
module tb_sha256_message_hasher_unit;

  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  // Settle time at the end: covers two compressions plus the padding bytes.
  localparam int unsigned TAIL_CYCLES    = 300;
  localparam int unsigned RANDOM_WORDS   = 330;
  localparam int unsigned PHASES         = 3;
  // Padding puts the 64-bit length in the last 8 bytes of a block.
  localparam int unsigned LENGTH_POS     = 56;

  // Initial hash value, word 0 in the top 32 bits.
  localparam logic [255:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Round constants, round 0 in the top 32 bits.
  localparam logic [2047:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  sha256mh_pkg::in_word_t  in_data   = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sha256mh_pkg::out_word_t out_data;

  // Hash state tracked alongside the block.
  logic [31:0]             hash_acc [8];
  logic [7:0]              block_buf [64];
  int unsigned             block_fill;
  logic [63:0]             msg_bits;
  sha256mh_pkg::out_word_t digest_q [$];
  sha256mh_pkg::out_word_t oldest_digest;

  // Sender idling: bursts of random length, gaps of random length up to gap_max.
  int unsigned burst_left = 0;
  int unsigned gap_max    = 0;
  // Receiver stalling: runs of random length, stalled with stall_pct percent odds.
  int unsigned stall_pct  = 0;
  int unsigned run_left   = 0;
  logic        stall_run  = 1'b0;
  // Long hold-off: the test bumps the request count, the stall process counts cycles.
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_seen     = 0;
  int unsigned holdoff_left     = 0;

  int unsigned errors          = 0;
  int unsigned words_sent      = 0;
  int unsigned messages_hashed = 0;
  int unsigned digests_checked = 0;
  int unsigned two_block_pads  = 0;

  sha256_message_hasher_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run; the slowest legal run needs well under a tenth of this.
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    int unsigned j;
    for (j = 0; j < 8; j++) hash_acc[j] = HASH_INIT[255 - 32 * j -: 32];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // Run the 64 rounds over block_buf and fold the result into hash_acc.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int unsigned r;
    for (r = 0; r < 16; r++)
      w[r] = {block_buf[4 * r], block_buf[4 * r + 1], block_buf[4 * r + 2], block_buf[4 * r + 3]};
    for (r = 16; r < 64; r++) begin
      s0   = rotr(w[r - 15], 7) ^ rotr(w[r - 15], 18) ^ (w[r - 15] >> 3);
      s1   = rotr(w[r - 2], 17) ^ rotr(w[r - 2], 19) ^ (w[r - 2] >> 10);
      w[r] = w[r - 16] + s0 + w[r - 7] + s1;
    end
    a = hash_acc[0]; b = hash_acc[1]; c = hash_acc[2]; d = hash_acc[3];
    e = hash_acc[4]; f = hash_acc[5]; g = hash_acc[6]; h = hash_acc[7];
    for (r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[2047 - 32 * r -: 32] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
    hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
  endfunction

  // Absorb one accepted word; on end of message pad, finish and queue the digest.
  function automatic void absorb_word(input sha256mh_pkg::in_word_t w);
    int unsigned             pos, k;
    sha256mh_pkg::out_word_t dw;
    if (w.byte_present) begin
      block_buf[block_fill] = w.data_byte;
      msg_bits   += 64'd8;
      block_fill  = (block_fill + 1) % 64;
      if (block_fill == 0) compress_block();
    end
    if (w.end_of_message) begin
      pos = block_fill;
      block_buf[pos] = sha256mh_pkg::PAD_MARK;
      pos++;
      // No room left for the length: close this block and pad a second one.
      if (pos > LENGTH_POS) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
        two_block_pads++;
      end
      while (pos < LENGTH_POS) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      for (k = 0; k < 8; k++) block_buf[LENGTH_POS + k] = msg_bits[63 - 8 * k -: 8];
      compress_block();
      for (k = 0; k < 8; k++) begin
        dw.digest_word = hash_acc[k];
        dw.word_number = k[2:0];
        dw.last_word   = (k == 7);
        digest_q.push_back(dw);
      end
      messages_hashed++;
      clear_hash_state();
    end
  endfunction

  function automatic sha256mh_pkg::in_word_t make_word(input logic [7:0] data,
                                                       input logic present,
                                                       input logic last);
    sha256mh_pkg::in_word_t w;
    w.data_byte      = data;
    w.byte_present   = present;
    w.end_of_message = last;
    return w;
  endfunction

  // Mostly short messages, some right at the padding edges, a few over two blocks.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 4) begin
      case ($urandom_range(0, 5))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        default: return 65;
      endcase
    end
    if (r == 4) return $urandom_range(118, 130);
    if (r == 5) return 0;
    return $urandom_range(1, 40);
  endfunction

  // Offer one word and hold it until taken. Sample the stall at the falling
  // edge: every input changes only at rising edges, so the handshake at the
  // next rising edge is settled by then.
  task automatic send_word(input sha256mh_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    absorb_word(w);
  endtask

  // Drop valid for a gap of length n; a zero gap keeps valid high into the next word.
  task automatic pause_input(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic put_word(input sha256mh_pkg::in_word_t w);
    send_word(w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pause_input($urandom_range(0, gap_max));
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender until every queued digest word has come out.
  task automatic wait_for_digests();
    if (digest_q.size() != 0) begin
      in_valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clk);
    end
  endtask

  // Send len random bytes, ending either on the last byte or with a bare marker.
  // Sprinkle in words with neither flag set; the block must ignore them.
  task automatic send_message(input int unsigned len);
    int unsigned i;
    logic        end_on_byte;
    end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 14) == 0)
        put_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      put_word(make_word(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1)));
      words_sent++;
    end
    if (!end_on_byte) begin
      put_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
      words_sent++;
    end
  endtask

  // Empty message, end on a byte, end on a bare marker, extreme byte values,
  // and a stray word with neither flag.
  task automatic test_directed_cases();
    stall_pct = 20;
    gap_max   = 2;
    put_word(make_word(8'h00, 1'b0, 1'b1));
    put_word(make_word("a", 1'b1, 1'b0));
    put_word(make_word("b", 1'b1, 1'b0));
    put_word(make_word("c", 1'b1, 1'b1));
    put_word(make_word("a", 1'b1, 1'b0));
    put_word(make_word("b", 1'b1, 1'b0));
    put_word(make_word("c", 1'b1, 1'b0));
    put_word(make_word(8'hff, 1'b0, 1'b1));
    put_word(make_word(8'hff, 1'b0, 1'b0));
    put_word(make_word(8'h00, 1'b1, 1'b0));
    put_word(make_word(8'hff, 1'b1, 1'b1));
    put_word(make_word(8'hff, 1'b1, 1'b0));
    put_word(make_word(8'h5a, 1'b0, 1'b0));
    put_word(make_word(8'ha5, 1'b0, 1'b1));
    wait_for_digests();
  endtask

  // Random messages in phases: no idling at all, then light, then heavy idling
  // on both sides. Drain now and then so the sender also restarts from idle.
  task automatic test_random_traffic();
    int unsigned phase, target;
    for (phase = 0; phase < PHASES; phase++) begin
      gap_max   = (phase == 0) ? 0 : (phase == 1) ? 3 : 8;
      stall_pct = (phase == 0) ? 0 : (phase == 1) ? 30 : 70;
      target    = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < target) begin
        send_message(pick_length());
        if ($urandom_range(0, 3) == 0) wait_for_digests();
      end
      wait_for_digests();
    end
  endtask

  // Stall the output for a long stretch while back-to-back messages keep
  // coming, so the block backs up and stalls its input.
  task automatic test_output_holdoff();
    int unsigned m;
    stall_pct = 0;
    gap_max   = 0;
    holdoff_requests++;
    for (m = 0; m < 4; m++) send_message($urandom_range(0, 20));
    wait_for_digests();
  endtask

  // Receiver stall: a requested hold-off wins, otherwise random runs.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left  = $urandom_range(1, 8);
        stall_run = ($urandom_range(0, 99) < stall_pct);
      end
      run_left--;
      out_stall <= stall_run;
    end
  end

  // Check each digest word taken at the next rising edge against the oldest
  // queued one, field by field.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, got %h number %0d last %0b",
                 $time, out_data.digest_word, out_data.word_number, out_data.last_word);
        errors++;
      end else begin
        oldest_digest = digest_q.pop_front();
        digests_checked++;
        if (out_data.digest_word !== oldest_digest.digest_word) begin
          $display("%0t: digest_word mismatch: expected %h, got %h",
                   $time, oldest_digest.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_number !== oldest_digest.word_number) begin
          $display("%0t: word_number mismatch: expected %0d, got %0d",
                   $time, oldest_digest.word_number, out_data.word_number);
          errors++;
        end
        if (out_data.last_word !== oldest_digest.last_word) begin
          $display("%0t: last_word mismatch: expected %0b, got %0b",
                   $time, oldest_digest.last_word, out_data.last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_hash_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_output_holdoff();
    // Give the block time to emit anything spurious before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digest_q.size() != 0) begin
      $display("%0t: %0d digest words never arrived", $time, digest_q.size());
      errors++;
    end
    $display("Hashed %0d messages (%0d padded over two blocks), %0d digest words checked.",
             messages_hashed, two_block_pads, digests_checked);
    $display("Traffic ran with and without idling on both sides and one long output hold.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sha256mh_pkg.sv
hdl/sha256mh_dp.sv
hdl/sha256mh_ctrl.sv
hdl/sha256_message_hasher_unit.sv
tb/tb_sha256_message_hasher_unit.sv
